// ===== rtl/core/m68k_immediate_and_bit_op_unit_macros.svh =====
// Assertion macros for the group-0 execute unit
`ifndef M68K_IMMEDIATE_AND_BIT_OP_UNIT_MACROS_SVH
`define M68K_IMMEDIATE_AND_BIT_OP_UNIT_MACROS_SVH
// Implication checked every cycle outside reset
`define M68K_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define M68K_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/m68k_ib_pkg.sv =====
// Shared types and constants for the group-0 execute unit
`default_nettype none
package m68k_ib_pkg;
    localparam logic [15:0] SR_RESET = 16'h2700;
    localparam int          QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_LOGIC = 3'd0;
    localparam logic [2:0] OP_ARITH = 3'd1;
    localparam logic [2:0] OP_CCR   = 3'd2;
    localparam logic [2:0] OP_SR    = 3'd3;
    localparam logic [2:0] OP_BIT   = 3'd4;
    localparam logic [2:0] OP_FAULT = 3'd5;

    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_SIZE = 2'd1;
    localparam logic [1:0] FLT_PRIV = 2'd2;
    localparam logic [1:0] FLT_ILL  = 2'd3;

    localparam logic [7:0] LO_CCR = 8'h3C;
    localparam logic [7:0] LO_SR  = 8'h7C;

    // Classified beat passed from front to back
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  hi;
        logic [1:0]  sz;
        logic        reg_mode;
        logic [1:0]  fault;
        logic [31:0] imm;
        logic [31:0] dst;
        logic [4:0]  bitnum;
    } t_uop;
endpackage
`default_nettype wire

// ===== rtl/core/m68k_ib_front.sv =====
// Front end: accept and classify group-0 instruction beats
`default_nettype none
module m68k_ib_front (
    input  wire logic [15:0]        i_opcode,
    input  wire logic [31:0]        i_immediate,
    input  wire logic [31:0]        i_dest_operand,
    input  wire logic [7:0]         i_bit_source,
    output m68k_ib_pkg::t_uop       o_uop
);
    logic [7:0] hi, lo;
    logic [7:0] num;
    assign hi  = i_opcode[15:8];
    assign lo  = i_opcode[7:0];
    assign num = (hi == 8'h08) ? i_immediate[7:0] : i_bit_source;

    // Decode group, form and static faults
    always_comb begin
        o_uop.hi       = hi;
        o_uop.sz       = lo[7:6];
        o_uop.reg_mode = (lo[5:3] == 3'd0);
        o_uop.imm      = i_immediate;
        o_uop.dst      = i_dest_operand;
        o_uop.bitnum   = (lo[5:3] == 3'd0) ? num[4:0] : {2'b00, num[2:0]};
        o_uop.fault    = m68k_ib_pkg::FLT_NONE;
        o_uop.op       = m68k_ib_pkg::OP_FAULT;
        if (hi[7:4] != 4'd0 || hi == 8'h0E) begin
            o_uop.fault = m68k_ib_pkg::FLT_ILL;
        end else if (hi == 8'h00 || hi == 8'h02 || hi == 8'h0A) begin
            if (lo == m68k_ib_pkg::LO_CCR) begin
                o_uop.op = m68k_ib_pkg::OP_CCR;
            end else if (lo == m68k_ib_pkg::LO_SR) begin
                if (hi == 8'h0A) o_uop.fault = m68k_ib_pkg::FLT_ILL;
                else             o_uop.op    = m68k_ib_pkg::OP_SR;
            end else if (lo[7:6] == 2'd3) begin
                o_uop.fault = m68k_ib_pkg::FLT_SIZE;
            end else begin
                o_uop.op = m68k_ib_pkg::OP_LOGIC;
            end
        end else if (hi == 8'h04 || hi == 8'h06 || hi == 8'h0C) begin
            if (lo[7:6] == 2'd3) o_uop.fault = m68k_ib_pkg::FLT_SIZE;
            else                 o_uop.op    = m68k_ib_pkg::OP_ARITH;
        end else if (lo[5:3] == 3'd1) begin
            o_uop.fault = m68k_ib_pkg::FLT_ILL;
        end else begin
            o_uop.op = m68k_ib_pkg::OP_BIT;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/m68k_ib_queue.sv =====
// Small FIFO between front and back
`default_nettype none
`include "m68k_immediate_and_bit_op_unit_macros.svh"
module m68k_ib_queue #(
    parameter int DEPTH = m68k_ib_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire m68k_ib_pkg::t_uop i_uop,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      m68k_ib_pkg::t_uop o_uop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    m68k_ib_pkg::t_uop r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_uop   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_uop;
    end

    `M68K_ASSERT_NXT(a_no_overflow, i_clk, i_rst_n, (r_cnt == (AW+1)'(DEPTH)) && !pop,
        r_cnt == (AW+1)'(DEPTH), "queue count changed while full without pop")
    `M68K_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH),
        "queue count out of range")
    `M68K_ASSERT_NXT(a_pop_moves, i_clk, i_rst_n, pop && !push,
        r_cnt == $past(r_cnt) - 1'b1, "pop did not reduce count")
endmodule
`default_nettype wire

// ===== rtl/core/m68k_ib_back.sv =====
// Back end: execute classified beats, hold SR, drive result register
`default_nettype none
`include "m68k_immediate_and_bit_op_unit_macros.svh"
module m68k_ib_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire m68k_ib_pkg::t_uop i_uop,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [31:0]       o_result_data,
    output      logic              o_write_back,
    output      logic [15:0]       o_status_word,
    output      logic [1:0]        o_fault
);
    logic [15:0] r_sr, n_sr;
    logic        r_vld;
    logic [31:0] n_res;
    logic        n_wb;
    logic [1:0]  n_flt;
    logic        fire;
    logic [31:0] m, top, s, d, r, bitm, bd;
    logic [32:0] sum;
    logic        v, c;

    assign o_ready = !r_vld || i_ready;
    assign fire    = i_valid && o_ready;
    assign o_valid = r_vld;

    // Execute one beat
    always_comb begin
        unique case (i_uop.sz)
            2'd0:    begin m = 32'hFF;   top = 32'h80;   end
            2'd1:    begin m = 32'hFFFF; top = 32'h8000; end
            default: begin m = '1;       top = 32'h8000_0000; end
        endcase
        s   = i_uop.imm & m;
        d   = i_uop.dst & m;
        sum = (i_uop.hi == 8'h06) ? ({1'b0, d} + {1'b0, s}) : ({1'b0, d} - {1'b0, s});
        r   = sum[31:0] & m;
        if (i_uop.hi == 8'h06) begin
            c = (r < d);
            v = ((s ^ r) & (d ^ r) & top) != '0;
        end else begin
            c = (s > d);
            v = ((s ^ d) & (r ^ d) & top) != '0;
        end
        bitm  = 32'd1 << i_uop.bitnum;
        bd    = i_uop.reg_mode ? i_uop.dst : {24'd0, i_uop.dst[7:0]};
        n_sr  = r_sr;
        n_res = '0;
        n_wb  = 1'b0;
        n_flt = i_uop.fault;
        unique case (i_uop.op)
            m68k_ib_pkg::OP_LOGIC: begin
                if (i_uop.hi == 8'h00)      n_res = d | s;
                else if (i_uop.hi == 8'h02) n_res = d & s;
                else                        n_res = d ^ s;
                n_sr[3:0] = {(n_res & top) != '0, n_res == '0, 2'b00};
                n_wb = 1'b1;
            end
            m68k_ib_pkg::OP_ARITH: begin
                n_sr[3:0] = {(r & top) != '0, r == '0, v, c};
                if (i_uop.hi != 8'h0C) begin
                    n_sr[4] = c;
                    n_res   = r;
                    n_wb    = 1'b1;
                end
            end
            m68k_ib_pkg::OP_CCR: begin
                if (i_uop.hi == 8'h00)      n_sr[4:0] = r_sr[4:0] | i_uop.imm[4:0];
                else if (i_uop.hi == 8'h02) n_sr[4:0] = r_sr[4:0] & i_uop.imm[4:0];
                else                        n_sr[4:0] = r_sr[4:0] ^ i_uop.imm[4:0];
            end
            m68k_ib_pkg::OP_SR: begin
                if (!r_sr[13])              n_flt = m68k_ib_pkg::FLT_PRIV;
                else if (i_uop.hi == 8'h00) n_sr = r_sr | i_uop.imm[15:0];
                else                        n_sr = r_sr & i_uop.imm[15:0];
            end
            m68k_ib_pkg::OP_BIT: begin
                n_sr[2] = (bd & bitm) == '0;
                unique case (i_uop.sz)
                    2'd0:    n_res = '0;
                    2'd1:    n_res = bd ^ bitm;
                    2'd2:    n_res = bd & ~bitm;
                    default: n_res = bd | bitm;
                endcase
                n_wb = (i_uop.sz != 2'd0);
            end
            default: ;
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr  <= m68k_ib_pkg::SR_RESET;
            r_vld <= 1'b0;
        end else begin
            if (fire) r_sr <= n_sr;
            if (fire) r_vld <= 1'b1;
            else if (i_ready) r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_result_data <= n_res;
            o_write_back  <= n_wb;
            o_status_word <= n_sr;
            o_fault       <= n_flt;
        end
    end

    `M68K_ASSERT_NXT(a_fault_holds_sr, i_clk, i_rst_n, fire && (n_flt != m68k_ib_pkg::FLT_NONE),
        $stable(r_sr), "status changed on faulting beat")
    `M68K_ASSERT_IMP(a_fault_no_wb, i_clk, i_rst_n, r_vld && (o_fault != m68k_ib_pkg::FLT_NONE),
        !o_write_back, "write-back on faulting beat")
    `M68K_ASSERT_IMP(a_res_zero, i_clk, i_rst_n, r_vld && !o_write_back,
        o_result_data == '0, "result nonzero without write-back")
endmodule
`default_nettype wire

// ===== rtl/core/m68k_immediate_and_bit_op_unit.sv =====
// 68000 group-0 execute unit: ORI/ANDI/SUBI/ADDI/EORI/CMPI and bit ops, one beat per cycle while
// the output is drained; a combinational decoder feeds a two-entry queue, and the executor holds SR
// and a result register, so a beat passes through the queue and then the result register.
`default_nettype none
module m68k_immediate_and_bit_op_unit #(
    parameter int QUEUE_DEPTH = m68k_ib_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [15:0] i_opcode,
    input  wire logic [31:0] i_immediate,
    input  wire logic [31:0] i_dest_operand,
    input  wire logic [7:0]  i_bit_source,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [31:0] o_result_data,
    output      logic        o_write_back,
    output      logic [15:0] o_status_word,
    output      logic [1:0]  o_fault
);
    m68k_ib_pkg::t_uop f_uop, q_uop;
    logic q_valid, q_ready;

    m68k_ib_front u_front (
        .i_opcode(i_opcode), .i_immediate(i_immediate),
        .i_dest_operand(i_dest_operand), .i_bit_source(i_bit_source), .o_uop(f_uop)
    );

    m68k_ib_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_uop(f_uop), .o_valid(q_valid), .i_ready(q_ready), .o_uop(q_uop)
    );

    m68k_ib_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_uop(q_uop), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_data(o_result_data), .o_write_back(o_write_back),
        .o_status_word(o_status_word), .o_fault(o_fault)
    );
endmodule
`default_nettype wire

// ===== verif/m68k_immediate_and_bit_op_unit_test.sv =====
// Self-checking testbench for the 68000 group-0 immediate and bit instruction unit
`default_nettype none
module m68k_immediate_and_bit_op_unit_test;

    localparam int IDLE_LIMIT = 2000;
    localparam logic [15:0] SR_S = 16'h2000;
    localparam logic [15:0] FLAG_X = 16'h0010;
    localparam logic [15:0] FLAG_N = 16'h0008;
    localparam logic [15:0] FLAG_Z = 16'h0004;
    localparam logic [15:0] FLAG_V = 16'h0002;
    localparam logic [15:0] FLAG_C = 16'h0001;
    localparam logic [7:0] GRP_ORI  = 8'h00;
    localparam logic [7:0] GRP_ANDI = 8'h02;
    localparam logic [7:0] GRP_SUBI = 8'h04;
    localparam logic [7:0] GRP_ADDI = 8'h06;
    localparam logic [7:0] GRP_BSTA = 8'h08;
    localparam logic [7:0] GRP_EORI = 8'h0A;
    localparam logic [7:0] GRP_CMPI = 8'h0C;
    localparam logic [7:0] GRP_BAD  = 8'h0E;

    typedef struct packed {
        logic [31:0] data;
        logic        wb;
        logic [15:0] sr;
        logic [1:0]  flt;
    } t_outcome;

    // Tracks SR and the queue of expected outcomes
    class sr_scoreboard;
        logic [15:0] sr;
        t_outcome    pending[$];
        int          errors;

        function void clear();
            sr = m68k_ib_pkg::SR_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function logic [31:0] size_mask(logic [1:0] sz);
            return (sz == 2'd0) ? 32'hFF : (sz == 2'd1) ? 32'hFFFF : 32'hFFFF_FFFF;
        endfunction

        function logic [31:0] size_msb(logic [1:0] sz);
            return (sz == 2'd0) ? 32'h80 : (sz == 2'd1) ? 32'h8000 : 32'h8000_0000;
        endfunction

        function void set_nzvc(logic [31:0] r, logic [1:0] sz, logic v, logic c,
                               logic keep_x);
            logic [15:0] f;
            f = 16'h0;
            if ((r & size_msb(sz)) != 0) f |= FLAG_N;
            if (r == 0) f |= FLAG_Z;
            if (v) f |= FLAG_V;
            if (c) f |= FLAG_C;
            if (keep_x) sr = (sr & ~16'h000F) | f;
            else begin
                if (c) f |= FLAG_X;
                sr = (sr & ~16'h001F) | f;
            end
        endfunction

        // Predict one instruction beat
        function void note_input(logic [15:0] op, logic [31:0] imm, logic [31:0] dst,
                                 logic [7:0] bsrc);
            logic [7:0] hi, lo;
            logic [1:0] sz;
            logic [2:0] mode;
            logic [31:0] m, top, s, d, r, bitm;
            logic [7:0] num;
            logic v, c;
            t_outcome o;
            hi = op[15:8];
            lo = op[7:0];
            sz = lo[7:6];
            mode = lo[5:3];
            o = '0;
            o.flt = m68k_ib_pkg::FLT_NONE;
            if (hi[7:4] != 0 || hi == GRP_BAD) begin
                o.flt = m68k_ib_pkg::FLT_ILL;
            end else if (hi == GRP_ORI || hi == GRP_ANDI || hi == GRP_EORI) begin
                if (lo == m68k_ib_pkg::LO_CCR) begin
                    if (hi == GRP_ORI) sr = sr | {11'h0, imm[4:0]};
                    else if (hi == GRP_ANDI) sr = sr & ~{11'h0, ~imm[4:0]};
                    else sr = sr ^ {11'h0, imm[4:0]};
                end else if (lo == m68k_ib_pkg::LO_SR) begin
                    if (hi == GRP_EORI) o.flt = m68k_ib_pkg::FLT_ILL;
                    else if ((sr & SR_S) == 0) o.flt = m68k_ib_pkg::FLT_PRIV;
                    else if (hi == GRP_ORI) sr = sr | imm[15:0];
                    else sr = sr & imm[15:0];
                end else if (sz == 2'd3) begin
                    o.flt = m68k_ib_pkg::FLT_SIZE;
                end else begin
                    m = size_mask(sz);
                    s = imm & m;
                    d = dst & m;
                    if (hi == GRP_ORI) r = d | s;
                    else if (hi == GRP_ANDI) r = d & s;
                    else r = d ^ s;
                    set_nzvc(r, sz, 1'b0, 1'b0, 1'b1);
                    o.data = r;
                    o.wb = 1'b1;
                end
            end else if (hi == GRP_SUBI || hi == GRP_ADDI || hi == GRP_CMPI) begin
                if (sz == 2'd3) o.flt = m68k_ib_pkg::FLT_SIZE;
                else begin
                    m = size_mask(sz);
                    top = size_msb(sz);
                    s = imm & m;
                    d = dst & m;
                    if (hi == GRP_ADDI) begin
                        r = (d + s) & m;
                        c = r < d;
                        v = ((s ^ r) & (d ^ r) & top) != 0;
                    end else begin
                        r = (d - s) & m;
                        c = s > d;
                        v = ((s ^ d) & (r ^ d) & top) != 0;
                    end
                    set_nzvc(r, sz, v, c, hi == GRP_CMPI);
                    if (hi != GRP_CMPI) begin
                        o.data = r;
                        o.wb = 1'b1;
                    end
                end
            end else if (mode == 3'd1) begin
                o.flt = m68k_ib_pkg::FLT_ILL;
            end else begin
                num = (hi == GRP_BSTA) ? imm[7:0] : bsrc;
                if (mode == 3'd0) begin
                    d = dst;
                    bitm = 32'h1 << num[4:0];
                end else begin
                    d = dst & 32'hFF;
                    bitm = 32'h1 << num[2:0];
                end
                if ((d & bitm) == 0) sr = sr | FLAG_Z;
                else sr = sr & ~FLAG_Z;
                if (sz != 2'd0) begin
                    if (sz == 2'd1) o.data = d ^ bitm;
                    else if (sz == 2'd2) o.data = d & ~bitm;
                    else o.data = d | bitm;
                    o.wb = 1'b1;
                end
            end
            o.sr = sr;
            pending.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result data=%h wb=%b sr=%h fault=%0d",
                         $time, got.data, got.wb, got.sr, got.flt);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.data !== want.data) begin
                $display("%0t: result_data expected %h actual %h", $time, want.data, got.data);
                errors++;
            end
            if (got.wb !== want.wb) begin
                $display("%0t: write_back expected %b actual %b", $time, want.wb, got.wb);
                errors++;
            end
            if (got.sr !== want.sr) begin
                $display("%0t: status_word expected %h actual %h", $time, want.sr, got.sr);
                errors++;
            end
            if (got.flt !== want.flt) begin
                $display("%0t: fault expected %0d actual %0d", $time, want.flt, got.flt);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, i_ready;
    logic [15:0] i_opcode;
    logic [31:0] i_immediate, i_dest_operand;
    logic [7:0]  i_bit_source;
    wire         o_ready, o_valid, o_write_back;
    wire  [31:0] o_result_data;
    wire  [15:0] o_status_word;
    wire  [1:0]  o_fault;

    m68k_immediate_and_bit_op_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_immediate(i_immediate), .i_dest_operand(i_dest_operand),
        .i_bit_source(i_bit_source), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_data(o_result_data), .o_write_back(o_write_back),
        .o_status_word(o_status_word), .o_fault(o_fault)
    );

    sr_scoreboard sb;
    int send_idle_pct, recv_stall_pct, quiet_cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_opcode = '0;
        i_immediate = '0;
        i_dest_operand = '0;
        i_bit_source = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sb = new();
        sb.clear();
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sample outputs and handshakes at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (i_valid && o_ready)
                sb.note_input(i_opcode, i_immediate, i_dest_operand, i_bit_source);
            if (o_valid && i_ready)
                sb.check_result({o_result_data, o_write_back, o_status_word, o_fault});
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one instruction beat and wait for its acceptance
    task automatic send_beat(logic [15:0] op, logic [31:0] imm, logic [31:0] dst,
                             logic [7:0] bsrc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_immediate <= imm;
        i_dest_operand <= dst;
        i_bit_source <= bsrc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 | $urandom_range(1);
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly valid group-0 forms, some noise
    task automatic send_random();
        logic [7:0] hi, lo;
        logic [7:0] groups[7];
        groups = '{GRP_ORI, GRP_ANDI, GRP_SUBI, GRP_ADDI, GRP_BSTA, GRP_EORI, GRP_CMPI};
        lo = 8'($urandom);
        case ($urandom_range(19))
            0: hi = 8'($urandom);
            1: hi = GRP_BAD;
            2, 3, 4, 5: hi = {4'h0, 3'($urandom), 1'b1};
            default: hi = groups[$urandom_range(6)];
        endcase
        case ($urandom_range(9))
            0: lo = m68k_ib_pkg::LO_CCR;
            1: lo = m68k_ib_pkg::LO_SR;
            2: lo[7:6] = 2'd3;
            default: if (lo[7:6] == 2'd3 && hi[0] == 1'b0 && hi != GRP_BSTA)
                lo[7:6] = 2'($urandom_range(2));
        endcase
        send_beat({hi, lo}, rand_word(), rand_word(), 8'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] g;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every group, size extremes, special forms
        send_beat({GRP_ORI, 8'h00}, 32'h0, 32'h0, 8'h0);
        send_beat({GRP_ANDI, 8'h40}, 32'hFFFF, 32'h8000, 8'h0);
        send_beat({GRP_EORI, 8'h80}, 32'hFFFF_FFFF, 32'h0, 8'h0);
        send_beat({GRP_ADDI, 8'h00}, 32'h01, 32'h7F, 8'h0);
        send_beat({GRP_ADDI, 8'h80}, 32'h1, 32'hFFFF_FFFF, 8'h0);
        send_beat({GRP_SUBI, 8'h40}, 32'h1, 32'h8000, 8'h0);
        send_beat({GRP_SUBI, 8'h80}, 32'h1, 32'h0, 8'h0);
        send_beat({GRP_CMPI, 8'h00}, 32'h5, 32'h5, 8'h0);
        send_beat({GRP_ORI, m68k_ib_pkg::LO_CCR}, 32'h1F, 32'h0, 8'h0);
        send_beat({GRP_ANDI, m68k_ib_pkg::LO_CCR}, 32'h0A, 32'h0, 8'h0);
        send_beat({GRP_EORI, m68k_ib_pkg::LO_CCR}, 32'h1F, 32'h0, 8'h0);
        send_beat({GRP_EORI, m68k_ib_pkg::LO_SR}, 32'h0, 32'h0, 8'h0);
        send_beat({GRP_ORI, 8'hC0}, 32'h0, 32'h0, 8'h0);
        send_beat({GRP_BSTA, 8'h00}, 32'h1F, 32'h8000_0000, 8'h0);
        send_beat({GRP_BSTA, 8'h50}, 32'hFF, 32'hFF, 8'h0);
        send_beat({8'h01, 8'h80}, 32'h0, 32'hFFFF_FFFF, 8'hFF);
        send_beat({8'h0F, 8'hC7}, 32'h0, 32'h0, 8'h27);
        send_beat({8'h03, 8'h08}, 32'h0, 32'h0, 8'h0);
        send_beat({GRP_BAD, 8'h00}, 32'h0, 32'h0, 8'h0);
        send_beat({8'hF0, 8'h00}, 32'h0, 32'h0, 8'h0);
        send_beat({GRP_ORI, m68k_ib_pkg::LO_SR}, 32'h0700, 32'h0, 8'h0);
        send_beat({GRP_ANDI, m68k_ib_pkg::LO_SR}, 32'h00FF, 32'h0, 8'h0);
        send_beat({GRP_ORI, m68k_ib_pkg::LO_SR}, 32'hFFFF, 32'h0, 8'h0);
        send_beat({GRP_ANDI, m68k_ib_pkg::LO_SR}, 32'hFFFF, 32'h0, 8'h0);
        drain();

        // Random phases with different idle and stall rates
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 64; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 64; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 170; n++) begin
                // Now and then return to supervisor mode via a known path is impossible
                // once S is clear, so SR forms keep S set most of the time
                if ($urandom_range(29) == 0) begin
                    g = ($urandom_range(1) == 0) ? GRP_ORI : GRP_ANDI;
                    send_beat({g, m68k_ib_pkg::LO_SR},
                              {16'h0, $urandom_range(3) == 0 ? 16'h0 : 16'h2000}
                              | ($urandom & 32'hFFFF), 32'h0, 8'h0);
                end else begin
                    send_random();
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
